### hw/rtl/ccnt_pkg.sv
// ----------------------------------------------------------------------------
// ccnt_pkg: shared constants and types of the cycle counter timebase.
// Widths, division constants and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ccnt_pkg;

    // Counter sample width and fraction width of the interval result.
    localparam int unsigned COUNTER_BITS  = 32;
    localparam int unsigned FRACTION_BITS = 24;

    // Port widths fixed by the field list.
    localparam int unsigned PORT_CNT_W = 32;
    localparam int unsigned FREQ_W     = 10;
    localparam int unsigned SEC_W      = 45;
    localparam int unsigned SUB_W      = 10;
    localparam int unsigned TOT_W      = 64;
    localparam int unsigned Q_W        = 37;
    localparam int unsigned WRAP_W     = 32;

    // Shared divider geometry.
    localparam int unsigned DIV_W  = 64;
    localparam int unsigned DVSR_W = 30;
    localparam int unsigned ITER_W = $clog2(DIV_W + 1);

    // Time constants.
    localparam int unsigned HZ_PER_MHZ  = 1000000;
    localparam int unsigned KHZ_PER_MHZ = 1000;
    localparam int unsigned US_PER_S    = 1000000;
    localparam int unsigned US_PER_MS   = 1000;
    // Cycles left below one millisecond stay under 1023 * 1000.
    localparam int unsigned SUBMS_W     = 20;

    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(168);

    // Division steps.
    typedef enum logic [2:0] {
        OP_US    = 3'd0,  // extended total / MHz -> total microseconds
        OP_SEC   = 3'd1,  // extended total / Hz -> seconds, cycles left
        OP_MS    = 3'd2,  // cycles left / kHz -> milliseconds, cycles left
        OP_MICRO = 3'd3,  // cycles left / MHz -> microseconds
        OP_EL    = 3'd4   // elapsed cycles * 2^fraction / Hz
    } div_op_t;

    typedef struct packed {
        logic    take_in;
        logic    start;
        logic    capture;
        div_op_t op;
        logic    load_out;
    } ccnt_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mode;
        logic out_free;
    } ccnt_sts_t;

endpackage

`default_nettype wire

### hw/rtl/ccnt_div.sv
// ----------------------------------------------------------------------------
// ccnt_div: iterative restoring divider.
// Produces one quotient bit a cycle for a left-aligned dividend; the number
// of steps is loaded with the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ccnt_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ccnt_pkg::DIV_W-1:0]    dividend,
    input  wire logic [ccnt_pkg::DVSR_W-1:0]   divisor,
    input  wire logic [ccnt_pkg::ITER_W-1:0]   iters,
    output logic                               done,
    output logic [ccnt_pkg::DIV_W-1:0]         quotient,
    output logic [ccnt_pkg::DVSR_W-1:0]        remainder
);
    import ccnt_pkg::*;

    logic [DIV_W-1:0]  q_reg,    q_next;
    logic [DVSR_W-1:0] rem_reg,  rem_next;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [ITER_W-1:0] cnt_reg,  cnt_next;
    logic              done_reg, done_next;
    logic [DVSR_W:0]   partial;
    logic [DVSR_W:0]   diff;
    logic              ge;

    assign partial = {rem_reg, q_reg[DIV_W-1]};
    assign diff    = partial - {1'b0, dvsr_reg};
    assign ge      = partial >= {1'b0, dvsr_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = iters;
        end
        else if (cnt_reg != '0)
        begin
            q_next    = {q_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[DVSR_W-1:0] : partial[DVSR_W-1:0];
            cnt_next  = cnt_reg - ITER_W'(1);
            done_next = (cnt_reg == ITER_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvsr_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/ccnt_dp.sv
// ----------------------------------------------------------------------------
// ccnt_dp: datapath of the cycle counter timebase.
// Holds the wrap detection state, the captured input word, the shared
// divider with its operand selection, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ccnt_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ccnt_pkg::ccnt_cmd_t               cmd,
    output ccnt_pkg::ccnt_sts_t                    sts,
    input  wire logic [ccnt_pkg::FREQ_W-1:0]       core_mhz,
    input  wire logic                              mode,
    input  wire logic [ccnt_pkg::PORT_CNT_W-1:0]   cycle_count,
    input  wire logic [ccnt_pkg::PORT_CNT_W-1:0]   previous_count,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ccnt_pkg::SEC_W-1:0]             seconds,
    output logic [ccnt_pkg::SUB_W-1:0]             millis,
    output logic [ccnt_pkg::SUB_W-1:0]             micros,
    output logic [ccnt_pkg::TOT_W-1:0]             total_micros,
    output logic [ccnt_pkg::PORT_CNT_W-1:0]        elapsed_cycles,
    output logic [ccnt_pkg::Q_W-1:0]               elapsed_seconds_q24
);
    import ccnt_pkg::*;

    logic [COUNTER_BITS-1:0] last_sample_reg;
    logic [WRAP_W-1:0]       wrap_count_reg;
    logic                    mode_reg;
    logic [COUNTER_BITS-1:0] sample_reg;
    logic [COUNTER_BITS-1:0] prev_reg;
    logic [COUNTER_BITS-1:0] in_sample;
    logic [COUNTER_BITS-1:0] el;

    logic [FREQ_W-1:0] mhz_eff;
    logic [DVSR_W-1:0] mhz_ext;
    logic [DVSR_W-1:0] hz_reg;
    logic [DVSR_W-1:0] hz_ms_reg;

    logic [DIV_W-1:0]  total;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVSR_W-1:0] div_divisor;
    logic [ITER_W-1:0] div_iters;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;
    logic [DVSR_W-1:0] div_rem;

    logic [TOT_W-1:0]   t_reg;
    logic [SEC_W-1:0]   secs_reg;
    logic [DVSR_W-1:0]  rem1_reg;
    logic [SUBMS_W-1:0] rem2_reg;
    logic [SUB_W-1:0]   ms_reg;
    logic [SUB_W-1:0]   us_reg;
    logic [Q_W-1:0]     q_reg;

    logic                  out_valid_reg;
    logic [SEC_W-1:0]      seconds_reg;
    logic [SUB_W-1:0]      millis_reg;
    logic [SUB_W-1:0]      micros_reg;
    logic [TOT_W-1:0]      total_micros_reg;
    logic [PORT_CNT_W-1:0] elapsed_cycles_reg;
    logic [Q_W-1:0]        elapsed_q_reg;

    assign in_sample = cycle_count[COUNTER_BITS-1:0];

    // Wrap detection and input capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
            wrap_count_reg  <= '0;
        end
        else if (cmd.take_in)
        begin
            last_sample_reg <= in_sample;
            if (in_sample < last_sample_reg)
            begin
                wrap_count_reg <= wrap_count_reg + WRAP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            mode_reg   <= mode;
            sample_reg <= in_sample;
            prev_reg   <= previous_count[COUNTER_BITS-1:0];
        end
    end

    // Clock in Hz and in kHz, refreshed every cycle from the frequency register.
    assign mhz_eff = (core_mhz == '0) ? FREQ_W'(1) : core_mhz;
    assign mhz_ext = DVSR_W'(mhz_eff);

    always_ff @(posedge clk)
    begin
        hz_reg    <= mhz_ext * DVSR_W'(HZ_PER_MHZ);
        hz_ms_reg <= mhz_ext * DVSR_W'(KHZ_PER_MHZ);
    end

    assign total = (DIV_W'(wrap_count_reg) << COUNTER_BITS) + DIV_W'(sample_reg);
    assign el    = sample_reg - prev_reg;

    always_comb
    begin
        case (cmd.op)
            OP_US:
            begin
                div_dividend = total;
                div_divisor  = mhz_ext;
                div_iters    = ITER_W'(DIV_W);
            end
            OP_SEC:
            begin
                div_dividend = total;
                div_divisor  = hz_reg;
                div_iters    = ITER_W'(DIV_W);
            end
            OP_MS:
            begin
                div_dividend = DIV_W'(rem1_reg) << (DIV_W - DVSR_W);
                div_divisor  = hz_ms_reg;
                div_iters    = ITER_W'(DVSR_W);
            end
            OP_MICRO:
            begin
                div_dividend = DIV_W'(rem2_reg) << (DIV_W - SUBMS_W);
                div_divisor  = mhz_ext;
                div_iters    = ITER_W'(SUBMS_W);
            end
            OP_EL:
            begin
                div_dividend = DIV_W'(el) << FRACTION_BITS;
                div_divisor  = hz_reg;
                div_iters    = ITER_W'(DIV_W);
            end
            default:
            begin
                div_dividend = total;
                div_divisor  = mhz_ext;
                div_iters    = ITER_W'(DIV_W);
            end
        endcase
    end

    ccnt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .iters     (div_iters),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Partial results of each division step.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            case (cmd.op)
                OP_US:
                begin
                    t_reg <= div_quot;
                end
                OP_SEC:
                begin
                    secs_reg <= div_quot[SEC_W-1:0];
                    rem1_reg <= div_rem;
                end
                OP_MS:
                begin
                    ms_reg   <= div_quot[SUB_W-1:0];
                    rem2_reg <= div_rem[SUBMS_W-1:0];
                end
                OP_MICRO:
                begin
                    us_reg <= div_quot[SUB_W-1:0];
                end
                OP_EL:
                begin
                    q_reg <= div_quot[Q_W-1:0];
                end
                default:
                begin
                    t_reg <= t_reg;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (mode_reg)
            begin
                seconds_reg        <= '0;
                millis_reg         <= '0;
                micros_reg         <= '0;
                total_micros_reg   <= '0;
                elapsed_cycles_reg <= PORT_CNT_W'(el);
                elapsed_q_reg      <= q_reg;
            end
            else
            begin
                seconds_reg        <= secs_reg;
                millis_reg         <= ms_reg;
                micros_reg         <= us_reg;
                total_micros_reg   <= t_reg;
                elapsed_cycles_reg <= '0;
                elapsed_q_reg      <= '0;
            end
        end
    end

    assign sts.div_done = div_done;
    assign sts.mode     = mode_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid           = out_valid_reg;
    assign seconds             = seconds_reg;
    assign millis              = millis_reg;
    assign micros              = micros_reg;
    assign total_micros        = total_micros_reg;
    assign elapsed_cycles      = elapsed_cycles_reg;
    assign elapsed_seconds_q24 = elapsed_q_reg;

endmodule

`default_nettype wire

### hw/rtl/ccnt_ctrl.sv
// ----------------------------------------------------------------------------
// ccnt_ctrl: sequencing controller of the cycle counter timebase.
// Steps the datapath through the division chain of the selected mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ccnt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ccnt_pkg::ccnt_sts_t   sts,
    output ccnt_pkg::ccnt_cmd_t        cmd
);
    import ccnt_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE        = 11'b00000000001,
        ST_LAUNCH      = 11'b00000000010,
        ST_WAIT_US     = 11'b00000000100,
        ST_START_SEC   = 11'b00000001000,
        ST_WAIT_SEC    = 11'b00000010000,
        ST_START_MS    = 11'b00000100000,
        ST_WAIT_MS     = 11'b00001000000,
        ST_START_MICRO = 11'b00010000000,
        ST_WAIT_MICRO  = 11'b00100000000,
        ST_WAIT_EL     = 11'b01000000000,
        ST_FINISH      = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.take_in  = 1'b0;
        cmd.start    = 1'b0;
        cmd.capture  = 1'b0;
        cmd.op       = OP_US;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                cmd.start = 1'b1;
                if (sts.mode)
                begin
                    cmd.op     = OP_EL;
                    state_next = ST_WAIT_EL;
                end
                else
                begin
                    cmd.op     = OP_US;
                    state_next = ST_WAIT_US;
                end
            end
            ST_WAIT_US:
            begin
                cmd.op = OP_US;
                if (sts.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_START_SEC;
                end
            end
            ST_START_SEC:
            begin
                cmd.op     = OP_SEC;
                cmd.start  = 1'b1;
                state_next = ST_WAIT_SEC;
            end
            ST_WAIT_SEC:
            begin
                cmd.op = OP_SEC;
                if (sts.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_START_MS;
                end
            end
            ST_START_MS:
            begin
                cmd.op     = OP_MS;
                cmd.start  = 1'b1;
                state_next = ST_WAIT_MS;
            end
            ST_WAIT_MS:
            begin
                cmd.op = OP_MS;
                if (sts.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_START_MICRO;
                end
            end
            ST_START_MICRO:
            begin
                cmd.op     = OP_MICRO;
                cmd.start  = 1'b1;
                state_next = ST_WAIT_MICRO;
            end
            ST_WAIT_MICRO:
            begin
                cmd.op = OP_MICRO;
                if (sts.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_WAIT_EL:
            begin
                cmd.op = OP_EL;
                if (sts.div_done)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

### hw/rtl/cycle_counter_timebase.sv
// ----------------------------------------------------------------------------
// cycle_counter_timebase: 64-bit extension of a 32-bit cycle counter.
// Mode 1 runs one division (64 divider steps) and mode 0 four (64 + 64 + 30 + 20
// steps); a start state launches and a capture closes each division, and the
// output register is loaded once it is free.
// Throughput: one word at a time; a new word is taken only once the last is loaded.
// Reset: rst_n clears the wrap state and the handshakes and sets the clock to 168 MHz.
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_counter_timebase (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration port.
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // Input channel.
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              mode,
    input  wire logic [ccnt_pkg::PORT_CNT_W-1:0]   cycle_count,
    input  wire logic [ccnt_pkg::PORT_CNT_W-1:0]   previous_count,
    // Output channel.
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ccnt_pkg::SEC_W-1:0]             seconds,
    output logic [ccnt_pkg::SUB_W-1:0]             millis,
    output logic [ccnt_pkg::SUB_W-1:0]             micros,
    output logic [ccnt_pkg::TOT_W-1:0]             total_micros,
    output logic [ccnt_pkg::PORT_CNT_W-1:0]        elapsed_cycles,
    output logic [ccnt_pkg::Q_W-1:0]               elapsed_seconds_q24
);
    import ccnt_pkg::*;

    // The only register, the core clock in MHz, sits at byte address 0. Bit 2
    // of the address selects the register; the low bits are ignored.
    localparam logic REG_IDX_CPU_FREQ = 1'b0;

    logic [FREQ_W-1:0] core_mhz_reg;
    logic              cfg_write;
    ccnt_cmd_t         cmd;
    ccnt_sts_t         sts;

    // The port never stalls, so a write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_mhz_reg <= FREQ_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_IDX_CPU_FREQ))
        begin
            core_mhz_reg <= pwdata[FREQ_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_CPU_FREQ) ? 32'(core_mhz_reg) : '0;

    // The controller walks the division chain of the selected mode. In mode 0
    // the extended total is divided by the MHz figure to give total
    // microseconds and by the clock in Hz to give whole seconds; the cycles
    // left over are divided by the clock in kHz, in a 30-step pass, to give
    // milliseconds, and what remains below one millisecond by the MHz figure,
    // in a 20-step pass, to give microseconds. Every divisor follows the
    // frequency register. In mode 1 the elapsed cycles, scaled by the
    // fraction bits, are divided once by the clock in Hz.
    ccnt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the wrap detection, the shared divider and the
    // output register, which lets a finished word wait for the consumer while
    // the next word is already taken in.
    ccnt_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .core_mhz            (core_mhz_reg),
        .mode                (mode),
        .cycle_count         (cycle_count),
        .previous_count      (previous_count),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .seconds             (seconds),
        .millis              (millis),
        .micros              (micros),
        .total_micros        (total_micros),
        .elapsed_cycles      (elapsed_cycles),
        .elapsed_seconds_q24 (elapsed_seconds_q24)
    );

endmodule

`default_nettype wire

### hw/rtl/ccnt_chk.sv
// ----------------------------------------------------------------------------
// ccnt_chk: port-level checks of the cycle counter timebase.
// Watches the handshakes and the result words and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccnt_chk (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic [ccnt_pkg::SEC_W-1:0]        seconds,
    input  wire logic [ccnt_pkg::SUB_W-1:0]        millis,
    input  wire logic [ccnt_pkg::SUB_W-1:0]        micros,
    input  wire logic [ccnt_pkg::TOT_W-1:0]        total_micros,
    input  wire logic [ccnt_pkg::PORT_CNT_W-1:0]   elapsed_cycles,
    input  wire logic [ccnt_pkg::Q_W-1:0]          elapsed_seconds_q24
);
    import ccnt_pkg::*;

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn before it was taken");

    // A stalled result word keeps its seconds, total and elapsed fields.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(seconds) && $stable(total_micros)
            && $stable(elapsed_cycles) && $stable(elapsed_seconds_q24))
        else $error("result word changed while stalled");

    // Only one word is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while the first is in work");

    // Sub-second parts stay below one thousand.
    a_sub_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (millis < SUB_W'(US_PER_MS)) && (micros < SUB_W'(US_PER_MS)))
        else $error("millisecond or microsecond part out of range");

endmodule

bind cycle_counter_timebase ccnt_chk u_ccnt_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .seconds             (seconds),
    .millis              (millis),
    .micros              (micros),
    .total_micros        (total_micros),
    .elapsed_cycles      (elapsed_cycles),
    .elapsed_seconds_q24 (elapsed_seconds_q24)
);

`default_nettype wire

### test/cycle_counter_timebase_test.sv
// ----------------------------------------------------------------------------
// cycle_counter_timebase_test: self-checking bench for the cycle counter timebase.
// Sends counter sample words through the valid/ready input and keeps its own
// predictor of the wrap count and both result forms. Every result word is
// compared field by field with the oldest prediction. The clock frequency
// register is reprogrammed between phases, covering the zero and out-of-range
// settings, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module cycle_counter_timebase_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ccnt_pkg::*;

    // Mode bit values and the register map: one register, at byte address 0.
    localparam logic       MODE_SPLIT    = 1'b0;
    localparam logic       MODE_INTERVAL = 1'b1;
    localparam logic [2:0] CPU_FREQ_ADDR = 3'd0;

    localparam int unsigned RANDOM_PER_SETTING = 140;
    localparam int unsigned SETTLE_CYCLES      = 4;
    // Longer than the slowest word takes, so this covers any straggler.
    localparam int unsigned FINAL_SETTLE       = 200;
    localparam int unsigned CYCLE_LIMIT        = 2000000;
    localparam int unsigned MAX_PRINTED        = 40;

    typedef struct packed {
        logic                  mode;
        logic [PORT_CNT_W-1:0] cycle_count;
        logic [PORT_CNT_W-1:0] previous_count;
    } count_word_t;

    typedef struct packed {
        logic [SEC_W-1:0]      seconds;
        logic [SUB_W-1:0]      millis;
        logic [SUB_W-1:0]      micros;
        logic [TOT_W-1:0]      total_micros;
        logic [PORT_CNT_W-1:0] elapsed_cycles;
        logic [Q_W-1:0]        elapsed_seconds_q24;
    } timestamp_t;

    // Every input is given a known value from time zero.
    logic                    clk            = 1'b0;
    logic                    rst_n          = 1'b0;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [2:0]              paddr          = '0;
    logic [31:0]             pwdata         = '0;
    logic [31:0]             prdata;
    logic                    pready;
    logic                    in_valid       = 1'b0;
    logic                    in_ready;
    logic                    mode           = 1'b0;
    logic [PORT_CNT_W-1:0]   cycle_count    = '0;
    logic [PORT_CNT_W-1:0]   previous_count = '0;
    logic                    out_valid;
    logic                    out_ready      = 1'b0;
    logic [SEC_W-1:0]        seconds;
    logic [SUB_W-1:0]        millis;
    logic [SUB_W-1:0]        micros;
    logic [TOT_W-1:0]        total_micros;
    logic [PORT_CNT_W-1:0]   elapsed_cycles;
    logic [Q_W-1:0]          elapsed_seconds_q24;

    cycle_counter_timebase dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .mode                (mode),
        .cycle_count         (cycle_count),
        .previous_count      (previous_count),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .seconds             (seconds),
        .millis              (millis),
        .micros              (micros),
        .total_micros        (total_micros),
        .elapsed_cycles      (elapsed_cycles),
        .elapsed_seconds_q24 (elapsed_seconds_q24)
    );

    // 4 ns clock period.
    initial
    begin : clock_gen
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the wrap tracking and the frequency
    // setting, updated as words are accepted and registers are written.
    // ------------------------------------------------------------------------
    logic [COUNTER_BITS-1:0] seen_sample  = '0;
    logic [WRAP_W-1:0]       seen_wraps   = '0;
    logic [FREQ_W-1:0]       freq_setting = FREQ_RESET;

    count_word_t pending_words[$];
    timestamp_t  predicted_stamps[$];
    count_word_t driven_word;

    int unsigned words_queued    = 0;
    int unsigned words_accepted  = 0;
    int unsigned results_checked = 0;
    int unsigned split_words     = 0;
    int unsigned interval_words  = 0;
    int unsigned wraps_seen      = 0;
    int unsigned settings_used   = 1;
    int unsigned mismatches      = 0;
    int unsigned cycles_run      = 0;

    // Random stimulus state: a free-running counter image and the last sample
    // sent, so that most words look like real successive counter reads.
    logic [PORT_CNT_W-1:0] stream_pos = '0;
    logic [PORT_CNT_W-1:0] last_sent  = '0;

    // Work out the result word for one accepted sample word. The wrap state
    // moves on in both modes, exactly as the block's own tracking does.
    function automatic timestamp_t predict_timestamp(count_word_t w);
        timestamp_t              r;
        logic [63:0]             cnt_mask;
        logic [63:0]             mhz;
        logic [63:0]             hz;
        logic [63:0]             hz_ms;
        logic [63:0]             total;
        logic [63:0]             secs;
        logic [63:0]             rem;
        logic [63:0]             ms;
        logic [63:0]             us;
        logic [63:0]             el;
        logic [63:0]             whole;
        logic [63:0]             frac;
        logic [COUNTER_BITS-1:0] sample;
        logic [COUNTER_BITS-1:0] prev;

        cnt_mask = (64'd1 << COUNTER_BITS) - 64'd1;
        sample   = COUNTER_BITS'(64'(w.cycle_count) & cnt_mask);
        prev     = COUNTER_BITS'(64'(w.previous_count) & cnt_mask);
        // A zero setting behaves as 1 MHz.
        mhz      = (freq_setting == '0) ? 64'd1 : 64'(freq_setting);
        hz       = mhz * 64'(HZ_PER_MHZ);
        hz_ms    = mhz * 64'(US_PER_MS);

        if (sample < seen_sample)
        begin
            seen_wraps = seen_wraps + 1'b1;
            wraps_seen++;
        end
        seen_sample = sample;

        r = '0;
        if (w.mode == MODE_SPLIT)
        begin
            split_words++;
            total = (64'(seen_wraps) << COUNTER_BITS) + 64'(sample);
            secs  = total / hz;
            rem   = total - secs * hz;
            ms    = rem / hz_ms;
            us    = (rem - ms * hz_ms) / mhz;
            r.seconds      = secs[SEC_W-1:0];
            r.millis       = ms[SUB_W-1:0];
            r.micros       = us[SUB_W-1:0];
            r.total_micros = secs * 64'(US_PER_S) + ms * 64'(US_PER_MS) + us;
        end
        else
        begin
            interval_words++;
            el    = (64'(sample) - 64'(prev)) & cnt_mask;
            whole = el / hz;
            rem   = el - whole * hz;
            frac  = (whole << FRACTION_BITS) + ((rem << FRACTION_BITS) / hz);
            r.elapsed_cycles      = el[PORT_CNT_W-1:0];
            r.elapsed_seconds_q24 = frac[Q_W-1:0];
        end
        return r;
    endfunction

    // One line per mismatch, up to a cap, so a badly broken build cannot
    // flood the log; every mismatch is still counted.
    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want,
                               int unsigned idx);
        if (got !== want)
            report_mismatch($sformatf("word %0d %s: got %0d, wanted %0d",
                                      idx, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Input driver. A word stays on the bus until it is accepted; after each
    // acceptance a gap of random length is drawn, except during quiet stretches
    // when words follow back to back. Every NBA below happens at most once per
    // edge, so the valid never drops and rises within one step.
    // ------------------------------------------------------------------------
    int unsigned send_gap     = 0;
    logic        sender_quiet = 1'b0;

    always @(posedge clk)
    begin : word_driver
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted_stamps.push_back(predict_timestamp(driven_word));
                words_accepted++;
                if ($urandom_range(0, 49) == 0)
                    sender_quiet = ~sender_quiet;
                send_gap = sender_quiet ? 0 : $urandom_range(0, 9);
            end
            if (!(in_valid && !in_ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    driven_word = pending_words.pop_front();
                    mode           <= driven_word.mode;
                    cycle_count    <= driven_word.cycle_count;
                    previous_count <= driven_word.previous_count;
                    in_valid       <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor. Each accepted result word is checked against the oldest
    // prediction; the receiver then stalls for a random spell, again with quiet
    // stretches in which it is always ready.
    // ------------------------------------------------------------------------
    int unsigned hold_cycles    = 0;
    logic        receiver_quiet = 1'b0;

    always @(posedge clk)
    begin : stamp_monitor
        timestamp_t got;
        timestamp_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.seconds             = seconds;
                got.millis              = millis;
                got.micros              = micros;
                got.total_micros        = total_micros;
                got.elapsed_cycles      = elapsed_cycles;
                got.elapsed_seconds_q24 = elapsed_seconds_q24;
                if (predicted_stamps.size() == 0)
                begin
                    report_mismatch($sformatf("result word %0d arrived with none pending",
                                              results_checked));
                end
                else
                begin
                    want = predicted_stamps.pop_front();
                    check_field("seconds", 64'(got.seconds), 64'(want.seconds),
                                results_checked);
                    check_field("millis", 64'(got.millis), 64'(want.millis),
                                results_checked);
                    check_field("micros", 64'(got.micros), 64'(want.micros),
                                results_checked);
                    check_field("total_micros", got.total_micros, want.total_micros,
                                results_checked);
                    check_field("elapsed_cycles", 64'(got.elapsed_cycles),
                                64'(want.elapsed_cycles), results_checked);
                    check_field("elapsed_seconds_q24", 64'(got.elapsed_seconds_q24),
                                64'(want.elapsed_seconds_q24), results_checked);
                end
                results_checked++;
                if ($urandom_range(0, 49) == 0)
                    receiver_quiet = ~receiver_quiet;
                hold_cycles = receiver_quiet ? 0 : $urandom_range(0, 9);
            end
            else if (hold_cycles != 0)
            begin
                hold_cycles--;
            end
            out_ready <= (hold_cycles == 0);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin : watchdog
        cycles_run++;
        if (cycles_run == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles_run, predicted_stamps.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic queue_word(logic m, logic [PORT_CNT_W-1:0] c,
                              logic [PORT_CNT_W-1:0] pc);
        count_word_t w;
        w.mode           = m;
        w.cycle_count    = c;
        w.previous_count = pc;
        pending_words.push_back(w);
        words_queued++;
        last_sent = c;
    endtask

    // Mostly a counter that moves forward by short, middling or long strides,
    // so wraps happen naturally; now and then a jump to anywhere as noise.
    task automatic queue_random_word();
        int unsigned           pick;
        logic [PORT_CNT_W-1:0] earlier;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            stream_pos = $urandom;
        else if (pick < 40)
            stream_pos = stream_pos + $urandom_range(0, 2000);
        else if (pick < 75)
            stream_pos = stream_pos + $urandom_range(0, 32'h00FF_FFFF);
        else
            stream_pos = stream_pos + $urandom_range(0, 32'h7FFF_FFFF);

        // The earlier sample is usually a plausible past read, sometimes the
        // previous word's sample and sometimes unrelated.
        pick = $urandom_range(0, 99);
        if (pick < 50)
            earlier = stream_pos - $urandom_range(0, 32'h00FF_FFFF);
        else if (pick < 75)
            earlier = last_sent;
        else
            earlier = $urandom;
        queue_word(1'($urandom_range(0, 1)), stream_pos, earlier);
    endtask

    // Wait until every queued word has been taken and every result checked.
    // Sampled on the falling edge so that it never races the clocked blocks.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (words_accepted != words_queued || predicted_stamps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Configuration write: setup cycle, then access cycle held until pready.
    // Spare upper data bits carry noise, which the register should ignore.
    task automatic write_cpu_freq(logic [FREQ_W-1:0] mhz);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CPU_FREQ_ADDR;
        pwdata  <= {(32 - FREQ_W)'($urandom), mhz};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        freq_setting  = mhz;
        settings_used++;
    endtask

    task automatic check_cpu_freq_readback();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CPU_FREQ_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[FREQ_W-1:0] !== freq_setting)
            report_mismatch($sformatf("core clock read back %0d, wanted %0d",
                                      prdata[FREQ_W-1:0], freq_setting));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence. The first phase runs at the reset frequency with the
    // directed words; each later phase reprograms the clock while the block is
    // idle, so the sender also pauses until every result is home.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [FREQ_W-1:0] plan [6];
        plan[0] = FREQ_W'(1);
        plan[1] = FREQ_W'(1000);
        plan[2] = FREQ_W'(0);       // treated as 1 MHz
        plan[3] = FREQ_W'(1023);    // above the documented range, used as given
        plan[4] = FREQ_W'($urandom_range(2, 999));
        plan[5] = FREQ_W'($urandom_range(1001, 1022));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        check_cpu_freq_readback();

        // Absolute time at zero and at one, the top of the counter, then a wrap back to
        // zero, followed by a repeat of the same sample, which is no wrap.
        queue_word(MODE_SPLIT, 32'h0000_0000, 32'h0000_0000);
        queue_word(MODE_SPLIT, 32'h0000_0001, 32'h0000_0000);
        queue_word(MODE_SPLIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_word(MODE_SPLIT, 32'h0000_0000, 32'h0000_0000);
        queue_word(MODE_SPLIT, 32'h0000_0000, 32'hFFFF_FFFF);
        // Intervals: one that wraps, the largest, one across a counter wrap
        // and a zero-length one.
        queue_word(MODE_INTERVAL, 32'h0000_0005, 32'h0000_000A);
        queue_word(MODE_INTERVAL, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_word(MODE_INTERVAL, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_word(MODE_INTERVAL, 32'h1234_5678, 32'h1234_5678);
        // Samples either side of one second's worth of cycles at 168 MHz.
        queue_word(MODE_SPLIT, 32'd167_999_999, 32'h0000_0000);
        queue_word(MODE_SPLIT, 32'd168_000_000, 32'h0000_0000);
        queue_word(MODE_INTERVAL, 32'd168_000_000, 32'h0000_0000);
        queue_word(MODE_INTERVAL, 32'd168_000, 32'h0000_0000);
        repeat (RANDOM_PER_SETTING) queue_random_word();
        wait_for_drain();

        for (int p = 0; p < 6; p++)
        begin
            write_cpu_freq(plan[p]);
            check_cpu_freq_readback();
            queue_word(MODE_INTERVAL, 32'hFFFF_FFFF, 32'h0000_0000);
            queue_word(MODE_SPLIT, 32'hFFFF_FFFF, $urandom);
            repeat (RANDOM_PER_SETTING) queue_random_word();
            wait_for_drain();
        end

        repeat (FINAL_SETTLE) @(posedge clk);

        $display("Covered %0d words (%0d absolute, %0d interval) over %0d clock settings,",
                 words_accepted, split_words, interval_words, settings_used);
        $display("with %0d counter wraps and %0d result words checked.",
                 wraps_seen, results_checked);
        if (mismatches == 0 && predicted_stamps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
